// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante; expects i_clk and i_rst_n in scope.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante; expects i_clk and i_rst_n in scope.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Check cons after a delay from ante; expects i_clk and i_rst_n in scope.
`define AST_AFTER3(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##3 (cons)) else $error(msg);

`endif

// ----- design/cmwc_pkg.sv -----
// Package with constants and types of the CMWC4096 random generator.
package cmwc_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // Arithmetic widths
    localparam int WORD_W  = 32;
    localparam int CARRY_W = 19;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = WORD_W + MULT_W;
    localparam int CY_W    = PROD_W - WORD_W;

    // Generator constants
    localparam logic [WORD_W-1:0]  GOLDEN_STEP = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  MWC_MULT    = 15'd18782;
    localparam logic [WORD_W-1:0]  COMPL_BASE  = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;

    // Function codes of an input word
    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL,
        ST_WB
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic seed_start;
        logic seed_step;
        logic draw_start;
        logic draw_mul;
        logic draw_wb;
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic seed_last;
    } t_dp_status;

endpackage

// ----- design/cmwc_ctrl.sv -----
// Controller state machine of the CMWC4096 random generator.
module cmwc_ctrl
    import cmwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_func,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       busy
);

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_func == FUNC_DRAW) begin
                        o_cmd.draw_start = 1'b1;
                        n_state          = ST_MUL;
                    end else begin
                        o_cmd.seed_start = 1'b1;
                        n_state          = ST_SEED;
                    end
                end
            end
            ST_SEED: begin
                o_cmd.seed_step = 1'b1;
                if (i_status.seed_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.draw_mul = 1'b1;
                n_state        = ST_WB;
            end
            ST_WB: begin
                o_cmd.draw_wb = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/cmwc_datapath.sv -----
// Datapath of the CMWC4096 random generator: lag table, carry, index, seeding.
module cmwc_datapath
    import cmwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [WORD_W-1:0] i_seed_value,
    output t_dp_status        o_status,
    output logic              o_strobe,
    output logic [WORD_W-1:0] o_random_word
);

    // Lag table memory
    logic [WORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // Generator state
    logic [IDX_W-1:0]   r_idx;
    logic [CARRY_W-1:0] r_carry;
    logic               r_valid;
    logic [PROD_W-1:0]  r_prod;

    // Seeding state
    logic [WORD_W-1:0] r_seed;
    logic [IDX_W-1:0]  r_k;
    logic [WORD_W-1:0] r_w1;
    logic [WORD_W-1:0] r_w2;
    logic [WORD_W-1:0] r_w3;

    // Result register
    logic              r_strobe;
    logic [WORD_W-1:0] r_word;

    // Combinational values
    logic [IDX_W-1:0]  idx_next;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] lag_word;
    logic [CY_W-1:0]   cy;
    logic [WORD_W:0]   sum;
    logic              wrap;
    logic [WORD_W-1:0] x;
    logic [CY_W:0]     cy_inc;
    logic [WORD_W-1:0] result;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // Advance the index with wrap
    assign idx_next = (r_idx == IDX_LAST) ? '0 : r_idx + IDX_W'(1);

    // Form the next seed word from the seed, the last word, or the words two and three back
    always_comb begin
        if (r_k == '0) begin
            seed_word = r_seed;
        end else if (r_k == IDX_W'(1) || r_k == IDX_W'(2)) begin
            seed_word = r_w1 + GOLDEN_STEP;
        end else begin
            seed_word = r_w3 ^ r_w2 ^ GOLDEN_STEP ^ WORD_W'(r_k);
        end
    end

    // Entries never written since reset read as zero
    assign lag_word = r_valid ? r_rdata : '0;

    // Fold the carry into the low half and complement
    always_comb begin
        cy     = r_prod[PROD_W-1:WORD_W];
        sum    = {1'b0, r_prod[WORD_W-1:0]} + (WORD_W+1)'(cy);
        wrap   = sum[WORD_W];
        x      = sum[WORD_W-1:0] + WORD_W'(wrap);
        cy_inc = (CY_W+1)'(cy) + (CY_W+1)'(wrap);
        result = COMPL_BASE - x;
    end

    // Select the table write
    assign mem_we    = i_cmd.seed_step | i_cmd.draw_wb;
    assign mem_waddr = i_cmd.seed_step ? r_k : r_idx;
    assign mem_wdata = i_cmd.seed_step ? seed_word : result;

    // Write and read the lag table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[idx_next];
    end

    // Hold index, carry and table-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= IDX_LAST;
            r_carry <= CARRY_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.draw_start) begin
                r_idx <= idx_next;
            end
            if (i_cmd.draw_wb) begin
                r_carry <= CARRY_W'(cy_inc);
            end
            if ((i_cmd.draw_wb && r_idx == IDX_LAST) ||
                (i_cmd.seed_step && r_k == IDX_LAST)) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Multiply the lag word and add the carry
    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_mul) begin
            r_prod <= PROD_W'(MWC_MULT) * PROD_W'(lag_word) + PROD_W'(r_carry);
        end
    end

    // Walk the table while seeding
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_seed <= i_seed_value;
            r_k    <= '0;
        end else if (i_cmd.seed_step) begin
            r_k  <= r_k + IDX_W'(1);
            r_w1 <= seed_word;
            r_w2 <= r_w1;
            r_w3 <= r_w2;
        end
    end

    // Register the result word and strobe it for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.draw_wb;
        end
        if (i_cmd.draw_wb) begin
            r_word <= result;
        end
    end

    assign o_status.seed_last = (r_k == IDX_LAST);
    assign o_strobe           = r_strobe;
    assign o_random_word      = r_word;

endmodule

// ----- design/cmwc4096_random_generator_unit.sv -----
// Top level of the CMWC4096 random generator.
//
// Usage:
//   Drive i_func and i_seed_value with start high; the command word is taken
//   at a rising edge where start is high and busy is low.
//   i_func = 0 reseeds the 4096-word lag table from i_seed_value and gives
//   no result; i_func = 1 draws one 32-bit word.
//   A draw reads the table at the accepting edge, keeps busy high through the
//   multiply and write-back states, and presents o_random_word with o_strobe high
//   from registers loaded in write-back; a new draw is taken only once busy falls.
//   A reseed writes one table word per cycle through the single write port,
//   so busy stays high until all 4096 entries are written.
//   The receiver cannot stall: each result word is on the outputs for
//   exactly one cycle and must be taken then.
//   Reset (i_rst_n low, synchronous) sets the carry to 362436 and the index
//   to the last entry; the table reads as all zero until it is written by a
//   reseed or a full lap of draws, so no clearing pass is needed and a
//   command can be accepted in the first cycle after reset.
module cmwc4096_random_generator_unit
    import cmwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_func,
    input  logic [WORD_W-1:0] i_seed_value,
    output logic              o_strobe,
    output logic [WORD_W-1:0] o_random_word
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequence the commands
    cmwc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Hold the table and compute words
    cmwc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_seed_value  (i_seed_value),
        .o_status      (status),
        .o_strobe      (o_strobe),
        .o_random_word (o_random_word)
    );

endmodule

// ----- design/cmwc_checker.sv -----
// Port-level assertion checker of the CMWC4096 random generator, with its bind.
`include "assert_macros.svh"

module cmwc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_func,
    input logic o_strobe
);

    // Accepted commands occupy the block
    `AST_NEXT(a_busy_after_accept, start && !busy, busy, "busy not raised after accept")

    // Results come out only while idle
    `AST_SAME(a_strobe_idle, o_strobe, !busy, "strobe while busy")

    // Every accepted draw yields a word after the multiply and write-back states
    `AST_AFTER3(a_draw_result, start && !busy && i_func, o_strobe, "draw gave no word")

    // Results never come in consecutive cycles
    `AST_NEXT(a_strobe_single, o_strobe, !o_strobe, "strobe held two cycles")

endmodule

bind cmwc4096_random_generator_unit cmwc_checker u_cmwc_checker (.*);

// ----- tb/tb_cmwc4096_random_generator_unit.sv -----
// Testbench for the CMWC4096 random generator: directed and random commands, scored in order.
module tb_cmwc4096_random_generator_unit
    import cmwc_pkg::*;
();

    localparam int CLK_HALF     = 4;
    localparam int RANDOM_WORDS = 500;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_func;
    logic [WORD_W-1:0] i_seed_value;
    logic              o_strobe;
    logic [WORD_W-1:0] o_random_word;

    // Generator state as the block should hold it
    logic [WORD_W-1:0]  lag_q [TABLE_DEPTH];
    logic [CARRY_W-1:0] mwc_carry;
    logic [IDX_W-1:0]   lag_idx;

    // Expected random words, oldest first
    logic [WORD_W-1:0] pending_words [$];

    int err_count;
    int cycle_count;
    int draw_count;
    int reseed_count;
    int wrap_count;
    int checked_count;

    cmwc4096_random_generator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_seed_value  (i_seed_value),
        .o_strobe      (o_strobe),
        .o_random_word (o_random_word)
    );

    // Free-running clock
    always #CLK_HALF i_clk = ~i_clk;

    // Rebuild the whole lag table from a seed; carry and index stay put
    function automatic void refill_lag_table(input logic [WORD_W-1:0] seed);
        lag_q[0] = seed;
        lag_q[1] = seed + GOLDEN_STEP;
        lag_q[2] = seed + GOLDEN_STEP + GOLDEN_STEP;
        for (int k = 3; k < TABLE_DEPTH; k++) begin
            lag_q[k] = lag_q[k-3] ^ lag_q[k-2] ^ GOLDEN_STEP ^ WORD_W'(k);
        end
    endfunction

    // Advance the index, run one multiply-with-carry step, write back and return the word
    function automatic logic [WORD_W-1:0] next_random_word();
        logic [63:0]       prod;
        logic [WORD_W-1:0] cy;
        logic [WORD_W-1:0] x;
        if (lag_idx >= IDX_LAST) begin
            lag_idx = '0;
        end else begin
            lag_idx = lag_idx + 1'b1;
        end
        prod = 64'(MWC_MULT) * 64'(lag_q[lag_idx]) + 64'(mwc_carry);
        cy   = prod[63:32];
        x    = prod[31:0] + cy;
        if (x < cy) begin
            x  = x + 1'b1;
            cy = cy + 1'b1;
            wrap_count++;
        end
        mwc_carry        = cy[CARRY_W-1:0];
        x                = COMPL_BASE - x;
        lag_q[lag_idx]   = x;
        return x;
    endfunction

    // Find a table word whose product plus carry overflows when the halves are summed
    function automatic logic [WORD_W-1:0] overflow_word(input logic [CARRY_W-1:0] cy_in);
        logic [63:0] t;
        for (int k = 18000; k > 0; k--) begin
            for (int d = 1; d <= k; d++) begin
                t = ((64'(k) + 64'd1) << 32) - 64'(d);
                if (t >= 64'(cy_in) && ((t - 64'(cy_in)) % 64'(MWC_MULT)) == 0) begin
                    return WORD_W'((t - 64'(cy_in)) / 64'(MWC_MULT));
                end
            end
        end
        return '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] exp_w,
                                   input logic [WORD_W-1:0] got_w);
        $display("MISMATCH %s at cycle %0d: expected %08h got %08h",
                 what, cycle_count, exp_w, got_w);
        err_count++;
    endtask

    // Present one command word and hold it until the block takes it
    task automatic issue_word(input logic func, input logic [WORD_W-1:0] seed);
        @(negedge i_clk);
        start        = 1'b1;
        i_func       = func;
        i_seed_value = seed;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (func == FUNC_DRAW) begin
            pending_words.push_back(next_random_word());
            draw_count++;
        end else begin
            refill_lag_table(seed);
            reseed_count++;
        end
    endtask

    // Drop start while putting noise on the fields
    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start        = 1'b0;
            i_func       = 1'($urandom());
            i_seed_value = $urandom();
        end
    endtask

    // Score each strobed word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", '0, o_random_word);
            end else begin
                if (o_random_word !== pending_words[0]) begin
                    report_mismatch("random_word", pending_words[0], o_random_word);
                end
                void'(pending_words.pop_front());
                checked_count++;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // First draw out of reset: index wraps to the first entry, carry is the reset value
    task automatic test_reset_draw();
        issue_word(FUNC_DRAW, 32'hffff_ffff);
    endtask

    // Seed the next slot so that the low half plus carry overflows 32 bits
    task automatic test_carry_wrap();
        logic [IDX_W-1:0]  nxt;
        logic [WORD_W-1:0] seed;
        // next slot is one of the first three, which are seed plus a multiple of the step
        nxt  = (lag_idx >= IDX_LAST) ? '0 : lag_idx + 1'b1;
        seed = overflow_word(mwc_carry) - GOLDEN_STEP * WORD_W'(nxt);
        issue_word(FUNC_RESEED, seed);
        issue_word(FUNC_DRAW, 32'h0);
    endtask

    // Reseed with edge values of the seed and draw a couple of words from each
    task automatic test_seed_extremes();
        logic [WORD_W-1:0] seeds [4];
        seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0001, 32'h61c8_8647};
        foreach (seeds[s]) begin
            issue_word(FUNC_RESEED, seeds[s]);
            issue_word(FUNC_DRAW, ~seeds[s]);
            hold_off(s + 1);
            issue_word(FUNC_DRAW, seeds[s]);
        end
    endtask

    // Draws held back to back at the full rate
    task automatic test_draw_streak();
        repeat (6) issue_word(FUNC_DRAW, $urandom());
    endtask

    // Random mix: mostly draws, rare reseeds, idle bursts except in the final stretch
    task automatic test_random_mix();
        logic func;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            func = ($urandom_range(0, 49) == 0) ? FUNC_RESEED : FUNC_DRAW;
            issue_word(func, $urandom());
            if (n < RANDOM_WORDS * 85 / 100 && $urandom_range(0, 2) == 0) begin
                hold_off($urandom_range(1, 4));
            end
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = FUNC_DRAW;
        i_seed_value = '0;
        err_count    = 0;
        cycle_count  = 0;
        draw_count   = 0;
        reseed_count = 0;
        wrap_count   = 0;
        checked_count = 0;
        foreach (lag_q[k]) lag_q[k] = '0;
        mwc_carry = CARRY_RESET;
        lag_idx   = IDX_LAST;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_draw();
        test_carry_wrap();
        test_seed_extremes();
        test_draw_streak();
        test_random_mix();

        // Drain: wait for the last words and any reseed still walking the table
        @(negedge i_clk);
        start = 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0 || busy !== 1'b0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d draws (%0d scored) and %0d reseeds in %0d cycles",
                 draw_count, checked_count, reseed_count, cycle_count);
        $display("Carry overflow path taken %0d times", wrap_count);
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
